FILE: rtl/kbtr_pkg.sv
// ----------------------------------------------------------------------------
// kbtr_pkg
// Shared types, constants and opcodes of the typematic auto-repeat engine.
// ----------------------------------------------------------------------------
package kbtr_pkg;

    // Time base and sequence sizes.
    localparam int TIME_BITS          = 48;
    localparam int SEQ_BYTES          = 8;
    localparam int MAX_SEQ            = 8;
    localparam int KEY_SLOTS_MAX      = 6;
    localparam int KEY_SLOTS_DEFAULT  = 6;
    localparam int INTERVAL_W         = 20;
    localparam int DELAY_MS_W         = 14;
    localparam int RATE_W             = 10;
    localparam int DELAY_US_W         = 24;

    // Defaults used when a timing register holds zero.
    localparam logic [DELAY_MS_W-1:0] DEFAULT_DELAY_MS = DELAY_MS_W'(500);
    localparam logic [RATE_W-1:0]     DEFAULT_RATE_CPS = RATE_W'(10);

    // Unit conversions.
    localparam logic [INTERVAL_W-1:0] US_PER_SEC = INTERVAL_W'(1000000);
    localparam logic [DELAY_US_W-1:0] US_PER_MS  = DELAY_US_W'(1000);

    // Iterative divider sizes.
    localparam int DIV_NUM_W = INTERVAL_W;
    localparam int DIV_DEN_W = RATE_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    // Request opcodes.
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_RAW    = 3'd1;
    localparam logic [2:0] OP_SEQ    = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_CANCEL = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_REPEAT_ENABLE = 2'd0;
    localparam logic [1:0] REG_DELAY_MS      = 2'd1;
    localparam logic [1:0] REG_RATE_CPS      = 2'd2;
    localparam logic [1:0] REG_CLICK_ENABLE  = 2'd3;

    // Characters that make up repeatable sequences.
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_BRACK  = 8'h5B;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_UP     = 8'h41;
    localparam logic [7:0] CH_DOWN   = 8'h42;
    localparam logic [7:0] CH_RIGHT  = 8'h43;
    localparam logic [7:0] CH_LEFT   = 8'h44;

    // Divider request and response.
    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } div_rsp_t;

    // Repeat state; all zero means no repeat armed.
    typedef struct packed {
        logic                      active;
        logic                      pending;
        logic [7:0]                bound;
        logic [7:0]                pcode;
        logic [8*SEQ_BYTES-1:0]    seq;
        logic [3:0]                len;
        logic [TIME_BITS-1:0]      due;
        logic [INTERVAL_W-1:0]     interval;
    } rpt_t;

endpackage

FILE: rtl/kbtr_div.sv
// ----------------------------------------------------------------------------
// kbtr_div
// Restoring divider that retires one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module kbtr_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  kbtr_pkg::div_req_t req,
    output kbtr_pkg::div_rsp_t rsp
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [kbtr_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [kbtr_pkg::DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [kbtr_pkg::DIV_DEN_W-1:0] den_reg, den_next;
    logic [kbtr_pkg::DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [kbtr_pkg::DIV_DEN_W:0]   shifted;
    logic [kbtr_pkg::DIV_DEN_W:0]   diff;
    logic                           fits;

    // One trial subtraction per cycle.
    assign shifted = {rem_reg, quo_reg[kbtr_pkg::DIV_NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = kbtr_pkg::DIV_CNT_W'(kbtr_pkg::DIV_NUM_W);
            rem_next  = '0;
            den_next  = req.divisor;
            quo_next  = req.dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[kbtr_pkg::DIV_DEN_W-1:0]
                            : shifted[kbtr_pkg::DIV_DEN_W-1:0];
            quo_next = {quo_reg[kbtr_pkg::DIV_NUM_W-2:0], fits};
            cnt_next = cnt_reg - kbtr_pkg::DIV_CNT_W'(1);
            if (cnt_reg == kbtr_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: rtl/keyboard_typematic_repeat.sv
// ----------------------------------------------------------------------------
// keyboard_typematic_repeat
// Typematic auto-repeat engine: forwards key sequences and re-emits
// repeatable ones on ticks after a delay, at a programmed rate.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_ready  opcode, now_us, seq_bytes,
//                                           seq_len, key_slots
// output    out        out_valid/out_ready  out_bytes, out_len, is_repeat,
//                                           click
// config    in         psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// A sequence that arms a repeat steps through SEQ, DIV (the restoring divider),
// ARM1, ARM2 and OUT; a tick through TICK, then DUE and OUT when it emits; other
// sequences through SEQ and OUT; raw reports through RAW; removals and cancels through CLEAR.
// in_ready is high only while the sequencer is idle; a finished result waits in
// the output register, and a new result stalls until that register drains.
// Reset is asynchronous.
//
module keyboard_typematic_repeat
#(
    parameter int KEY_SLOTS = kbtr_pkg::KEY_SLOTS_DEFAULT
)
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [2:0]                     opcode,
    input  logic [kbtr_pkg::TIME_BITS-1:0] now_us,
    input  logic [63:0]                    seq_bytes,
    input  logic [3:0]                     seq_len,
    input  logic [47:0]                    key_slots,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [63:0]                    out_bytes,
    output logic [3:0]                     out_len,
    output logic                           is_repeat,
    output logic                           click,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK,
        S_DUE,
        S_RAW,
        S_SEQ,
        S_DIV,
        S_ARM1,
        S_ARM2,
        S_CLEAR,
        S_OUT
    } state_t;

    localparam int TB = kbtr_pkg::TIME_BITS;

    // Configuration registers.
    logic                              repeat_enable_reg;
    logic [kbtr_pkg::DELAY_MS_W-1:0]   repeat_delay_ms_reg;
    logic [kbtr_pkg::RATE_W-1:0]       repeat_rate_cps_reg;
    logic                              click_enable_reg;
    logic                              cfg_write;
    logic [1:0]                        cfg_index;

    // Sequencer and repeat state.
    state_t                            state_reg, state_next;
    kbtr_pkg::rpt_t                    rpt_reg, rpt_next;
    logic [7:0]                        prior_reg [KEY_SLOTS];
    logic [7:0]                        prior_next [KEY_SLOTS];

    // Latched request.
    logic [2:0]                        op_reg, op_next;
    logic [TB-1:0]                     now_reg, now_next;
    logic [63:0]                       bytes_reg, bytes_next;
    logic [3:0]                        len_reg, len_next;
    logic [47:0]                       slots_reg, slots_next;
    logic [kbtr_pkg::DELAY_US_W-1:0]   delay_us_reg, delay_us_next;

    // Pending result and output register.
    logic [63:0]                       res_bytes_reg, res_bytes_next;
    logic [3:0]                        res_len_reg, res_len_next;
    logic                              res_rep_reg, res_rep_next;
    logic                              res_click_reg, res_click_next;
    logic                              out_valid_reg, out_valid_next;
    logic [63:0]                       out_bytes_reg, out_bytes_next;
    logic [3:0]                        out_len_reg, out_len_next;
    logic                              out_rep_reg, out_rep_next;
    logic                              out_click_reg, out_click_next;

    // Divider link.
    kbtr_pkg::div_req_t                div_req;
    kbtr_pkg::div_rsp_t                div_rsp;

    // Shared time compare and decode helpers.
    logic [TB-1:0]                     due_diff;
    logic                              now_before_due;
    logic                              due_before_now;
    logic [kbtr_pkg::DELAY_MS_W-1:0]   delay_ms_eff;
    logic [kbtr_pkg::RATE_W-1:0]       rate_eff;
    logic [63:0]                       masked_bytes;
    logic [3:0]                        eff_len;
    logic                              arm;
    logic [7:0]                        codes [KEY_SLOTS];
    logic                              bound_down;
    logic                              any_key;
    logic [7:0]                        fresh;
    logic                              seen;

    // Repeatable sequences: printable characters, CR, LF, BS, DEL,
    // the four arrows and the delete key.
    function automatic logic is_repeatable(input logic [63:0] b, input logic [3:0] len,
                                           input logic en);
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
        logic       r;
        c0 = b[7:0];
        c1 = b[15:8];
        c2 = b[23:16];
        c3 = b[31:24];
        r  = 1'b0;
        if (!en || len == 4'd0 || 32'(len) > kbtr_pkg::MAX_SEQ)
            r = 1'b0;
        else if (len == 4'd1)
            r = (c0 == kbtr_pkg::CH_LF) || (c0 == kbtr_pkg::CH_CR) ||
                (c0 == kbtr_pkg::CH_BS) || (c0 == kbtr_pkg::CH_DEL) ||
                ((c0 >= kbtr_pkg::CH_SPACE) && (c0 < kbtr_pkg::CH_DEL));
        else if (len == 4'd3 && c0 == kbtr_pkg::CH_ESC && c1 == kbtr_pkg::CH_BRACK)
            r = (c2 == kbtr_pkg::CH_UP) || (c2 == kbtr_pkg::CH_DOWN) ||
                (c2 == kbtr_pkg::CH_RIGHT) || (c2 == kbtr_pkg::CH_LEFT);
        else if (len == 4'd4 && c0 == kbtr_pkg::CH_ESC && c1 == kbtr_pkg::CH_BRACK &&
                 c2 == kbtr_pkg::CH_THREE && c3 == kbtr_pkg::CH_TILDE)
            r = 1'b1;
        return r;
    endfunction

    // Configuration port: writes land on the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_enable_reg   <= 1'b1;
            repeat_delay_ms_reg <= '0;
            repeat_rate_cps_reg <= '0;
            click_enable_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                kbtr_pkg::REG_REPEAT_ENABLE: repeat_enable_reg <= pwdata[0];
                kbtr_pkg::REG_DELAY_MS:
                    repeat_delay_ms_reg <= pwdata[kbtr_pkg::DELAY_MS_W-1:0];
                kbtr_pkg::REG_RATE_CPS:
                    repeat_rate_cps_reg <= pwdata[kbtr_pkg::RATE_W-1:0];
                kbtr_pkg::REG_CLICK_ENABLE:  click_enable_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        unique case (cfg_index)
            kbtr_pkg::REG_REPEAT_ENABLE: prdata = {31'd0, repeat_enable_reg};
            kbtr_pkg::REG_DELAY_MS:      prdata = 32'(repeat_delay_ms_reg);
            kbtr_pkg::REG_RATE_CPS:      prdata = 32'(repeat_rate_cps_reg);
            kbtr_pkg::REG_CLICK_ENABLE:  prdata = {31'd0, click_enable_reg};
            default:                     prdata = '0;
        endcase
    end

    // Wrapping time order between the stored due time and the request time.
    assign due_diff       = rpt_reg.due - now_reg;
    assign now_before_due = (due_diff != '0) && !due_diff[TB-1];
    assign due_before_now = due_diff[TB-1] && (due_diff[TB-2:0] != '0);

    assign delay_ms_eff = (repeat_delay_ms_reg == '0) ? kbtr_pkg::DEFAULT_DELAY_MS
                                                      : repeat_delay_ms_reg;
    assign rate_eff     = (repeat_rate_cps_reg == '0) ? kbtr_pkg::DEFAULT_RATE_CPS
                                                      : repeat_rate_cps_reg;

    // Sequence length clamp and byte mask.
    assign eff_len = (len_reg > 4'd8) ? 4'd8 : len_reg;

    always_comb
    begin
        for (int i = 0; i < kbtr_pkg::SEQ_BYTES; i++)
            masked_bytes[8*i +: 8] = (4'(i) < eff_len) ? bytes_reg[8*i +: 8] : 8'd0;
    end

    assign arm = is_repeatable(masked_bytes, len_reg, repeat_enable_reg);

    // Raw report decode: bound key still held, any key down, first new key.
    always_comb
    begin
        bound_down = 1'b0;
        any_key    = 1'b0;
        fresh      = 8'd0;
        seen       = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            codes[i] = slots_reg[8*i +: 8];
            if (codes[i] == rpt_reg.bound)
                bound_down = 1'b1;
            if (codes[i] != 8'd0)
                any_key = 1'b1;
        end
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            if (fresh == 8'd0 && codes[i] != 8'd0)
            begin
                seen = 1'b0;
                for (int j = 0; j < KEY_SLOTS; j++)
                    if (prior_reg[j] == codes[i])
                        seen = 1'b1;
                if (!seen)
                    fresh = codes[i];
            end
        end
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        rpt_next       = rpt_reg;
        prior_next     = prior_reg;
        op_next        = op_reg;
        now_next       = now_reg;
        bytes_next     = bytes_reg;
        len_next       = len_reg;
        slots_next     = slots_reg;
        delay_us_next  = delay_us_reg;
        res_bytes_next = res_bytes_reg;
        res_len_next   = res_len_reg;
        res_rep_next   = res_rep_reg;
        res_click_next = res_click_reg;
        div_req.start    = 1'b0;
        div_req.dividend = kbtr_pkg::US_PER_SEC;
        div_req.divisor  = rate_eff;

        // The output register drains independently of the sequencer.
        out_valid_next = out_valid_reg && !out_ready;
        out_bytes_next = out_bytes_reg;
        out_len_next   = out_len_reg;
        out_rep_next   = out_rep_reg;
        out_click_next = out_click_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    now_next   = now_us;
                    bytes_next = seq_bytes;
                    len_next   = seq_len;
                    slots_next = key_slots;
                    priority case (opcode)
                        kbtr_pkg::OP_TICK:   state_next = S_TICK;
                        kbtr_pkg::OP_RAW:    state_next = S_RAW;
                        kbtr_pkg::OP_SEQ:    state_next = S_SEQ;
                        kbtr_pkg::OP_REMOVE: state_next = S_CLEAR;
                        kbtr_pkg::OP_CANCEL: state_next = S_CLEAR;
                        default:             state_next = S_IDLE;
                    endcase
                end
            end

            // Tick: bind a pending repeat, then check whether one is due.
            S_TICK:
            begin
                state_next = S_IDLE;
                if (rpt_reg.pending && rpt_reg.pcode != 8'd0)
                begin
                    rpt_next.bound   = rpt_reg.pcode;
                    rpt_next.active  = 1'b1;
                    rpt_next.pending = 1'b0;
                    rpt_next.pcode   = 8'd0;
                    if (due_before_now)
                        rpt_next.due = now_reg;
                end
                if (rpt_next.active)
                begin
                    if (rpt_next.bound == 8'd0)
                        rpt_next = '0;
                    else if (now_before_due)
                        state_next = S_IDLE;
                    else if (rpt_reg.interval == '0)
                        rpt_next = '0;
                    else
                        state_next = S_DUE;
                end
            end

            // Repeat emission and next due time.
            S_DUE:
            begin
                rpt_next.due   = now_reg + TB'(rpt_reg.interval);
                res_bytes_next = rpt_reg.seq;
                res_len_next   = rpt_reg.len;
                res_rep_next   = 1'b1;
                res_click_next = click_enable_reg;
                state_next     = S_OUT;
            end

            // Raw report: release check, new key capture, key history.
            S_RAW:
            begin
                state_next = S_IDLE;
                if (rpt_reg.active && rpt_reg.bound != 8'd0 && !bound_down)
                    rpt_next = '0;
                if (fresh != 8'd0)
                    rpt_next.pcode = fresh;
                else if (!any_key)
                    rpt_next = '0;
                for (int i = 0; i < KEY_SLOTS; i++)
                    prior_next[i] = codes[i];
                if (rpt_next.pending && rpt_next.pcode != 8'd0)
                begin
                    rpt_next.bound   = rpt_next.pcode;
                    rpt_next.active  = 1'b1;
                    rpt_next.pending = 1'b0;
                    rpt_next.pcode   = 8'd0;
                    if (due_before_now)
                        rpt_next.due = now_reg;
                end
            end

            // Key sequence: forward it, and start arming if repeatable.
            S_SEQ:
            begin
                state_next = S_OUT;
                if (len_reg == 4'd0)
                begin
                    rpt_next       = '0;
                    res_bytes_next = '0;
                    res_len_next   = 4'd0;
                    res_rep_next   = 1'b0;
                    res_click_next = 1'b0;
                end
                else
                begin
                    if (rpt_reg.active || rpt_reg.pending)
                        rpt_next = '0;
                    res_bytes_next = masked_bytes;
                    res_len_next   = eff_len;
                    res_rep_next   = 1'b0;
                    res_click_next = click_enable_reg;
                    if (arm)
                    begin
                        div_req.start = 1'b1;
                        delay_us_next = kbtr_pkg::DELAY_US_W'(delay_ms_eff) *
                                        kbtr_pkg::US_PER_MS;
                        state_next    = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                if (div_rsp.done)
                    state_next = S_ARM1;
            end

            // Arm the repeat with the computed interval and delay.
            S_ARM1:
            begin
                rpt_next.seq      = res_bytes_reg;
                rpt_next.len      = len_reg;
                rpt_next.pending  = 1'b1;
                rpt_next.active   = 1'b0;
                rpt_next.bound    = 8'd0;
                rpt_next.interval = div_rsp.quotient;
                rpt_next.due      = now_reg + TB'(delay_us_reg);
                state_next        = S_ARM2;
            end

            // Bind at once if a new key is already waiting.
            S_ARM2:
            begin
                if (rpt_reg.pcode != 8'd0)
                begin
                    rpt_next.bound   = rpt_reg.pcode;
                    rpt_next.active  = 1'b1;
                    rpt_next.pending = 1'b0;
                    rpt_next.pcode   = 8'd0;
                    if (due_before_now)
                        rpt_next.due = now_reg;
                end
                state_next = S_OUT;
            end

            // Device removal also forgets the key history; cancel does not.
            S_CLEAR:
            begin
                rpt_next = '0;
                if (op_reg == kbtr_pkg::OP_REMOVE)
                    for (int i = 0; i < KEY_SLOTS; i++)
                        prior_next[i] = 8'd0;
                state_next = S_IDLE;
            end

            // Hand the result to the output register once it is free.
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_bytes_next = res_bytes_reg;
                    out_len_next   = res_len_reg;
                    out_rep_next   = res_rep_reg;
                    out_click_next = res_click_reg;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // State, repeat registers and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rpt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < KEY_SLOTS; i++)
                prior_reg[i] <= 8'd0;
        end
        else
        begin
            state_reg     <= state_next;
            rpt_reg       <= rpt_next;
            out_valid_reg <= out_valid_next;
            prior_reg     <= prior_next;
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        now_reg       <= now_next;
        bytes_reg     <= bytes_next;
        len_reg       <= len_next;
        slots_reg     <= slots_next;
        delay_us_reg  <= delay_us_next;
        res_bytes_reg <= res_bytes_next;
        res_len_reg   <= res_len_next;
        res_rep_reg   <= res_rep_next;
        res_click_reg <= res_click_next;
        out_bytes_reg <= out_bytes_next;
        out_len_reg   <= out_len_next;
        out_rep_reg   <= out_rep_next;
        out_click_reg <= out_click_next;
    end

    // Interval divider: one million over the effective rate.
    kbtr_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_bytes = out_bytes_reg;
    assign out_len   = out_len_reg;
    assign is_repeat = out_rep_reg;
    assign click     = out_click_reg;

`ifndef NO_ASSERTIONS
    // A repeat is never both waiting for a key and running.
    a_active_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !(rpt_reg.active && rpt_reg.pending))
        else $error("repeat both active and pending");

    // A running repeat is always bound to a key.
    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_reg.active |-> (rpt_reg.bound != 8'd0))
        else $error("active repeat without bound key");

    // Repeat emissions always carry a non-empty sequence.
    a_repeat_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_rep_reg) |-> (out_len_reg != 4'd0))
        else $error("repeat emission with empty sequence");

    // The divider only finishes while the sequencer waits for it.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider finished outside its wait state");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Typematic repeat engine testbench
// Drives key sequences, raw key reports, ticks, removals and cancels into the
// engine under several register settings and pacing modes. A scoreboard
// tracks the repeat state on its own and checks every emitted sequence.
// ----------------------------------------------------------------------------

import kbtr_pkg::*;

localparam int MAX_REPORTS = 10;

// Tracks the repeat state and holds the emissions still owed by the engine.
class repeat_scoreboard;

    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  len;
        logic        rep;
        logic        click;
    } emission_t;

    // Register copies.
    bit                    rpt_enable;
    logic [DELAY_MS_W-1:0] delay_ms;
    logic [RATE_W-1:0]     rate_cps;
    bit                    click_on;

    // Repeat state.
    bit                    active;
    bit                    pending;
    logic [7:0]            bound;
    logic [7:0]            pcode;
    logic [63:0]           seq;
    logic [3:0]            seq_n;
    logic [TIME_BITS-1:0]  due;
    logic [INTERVAL_W-1:0] interval;
    logic [7:0]            held [KEY_SLOTS_MAX];

    emission_t awaited [$];
    int        errors;
    int        results;
    int        repeats;

    function new();
        rpt_enable = 1'b1;
        delay_ms   = '0;
        rate_cps   = '0;
        click_on   = 1'b0;
        clear_repeat();
        foreach (held[i])
            held[i] = 8'h00;
    endfunction

    function void clear_repeat();
        active   = 1'b0;
        pending  = 1'b0;
        bound    = '0;
        pcode    = '0;
        seq      = '0;
        seq_n    = '0;
        due      = '0;
        interval = '0;
    endfunction

    // True when time a lies strictly before time b on the wrapping time line.
    function bit earlier(logic [TIME_BITS-1:0] a, logic [TIME_BITS-1:0] b);
        logic [TIME_BITS-1:0] d;
        d = b - a;
        return d != 0 && !d[TIME_BITS-1];
    endfunction

    // Binds an armed repeat to the newly pressed key, if there is one.
    function void bind_key(logic [TIME_BITS-1:0] now);
        if (!pending || pcode == 0)
            return;
        bound   = pcode;
        active  = 1'b1;
        pending = 1'b0;
        if (earlier(due, now))
            due = now;
        pcode = '0;
    endfunction

    function bit can_repeat(logic [63:0] b, logic [3:0] n);
        logic [7:0] c0, c1, c2, c3;
        c0 = b[7:0];
        c1 = b[15:8];
        c2 = b[23:16];
        c3 = b[31:24];
        if (!rpt_enable || n == 0 || n > MAX_SEQ)
            return 1'b0;
        if (n == 1)
            return c0 == CH_LF || c0 == CH_CR || c0 == CH_BS || c0 == CH_DEL ||
                   (c0 >= CH_SPACE && c0 < CH_DEL);
        if (n == 3 && c0 == CH_ESC && c1 == CH_BRACK)
            return c2 == CH_UP || c2 == CH_DOWN || c2 == CH_RIGHT || c2 == CH_LEFT;
        if (n == 4 && c0 == CH_ESC && c1 == CH_BRACK && c2 == CH_THREE && c3 == CH_TILDE)
            return 1'b1;
        return 1'b0;
    endfunction

    function void owe(logic [63:0] bytes, logic [3:0] n, logic rep, logic clk_flag);
        emission_t e;
        e.bytes = bytes;
        e.len   = n;
        e.rep   = rep;
        e.click = clk_flag;
        awaited.push_back(e);
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
        case (idx)
            REG_REPEAT_ENABLE: rpt_enable = value[0];
            REG_DELAY_MS:      delay_ms   = value[DELAY_MS_W-1:0];
            REG_RATE_CPS:      rate_cps   = value[RATE_W-1:0];
            REG_CLICK_ENABLE:  click_on   = value[0];
            default: ;
        endcase
    endfunction

    // Advances the state by one accepted request and notes any emission it owes.
    function void note_request(logic [2:0] op, logic [TIME_BITS-1:0] now,
                               logic [63:0] bytes, logic [3:0] n, logic [47:0] slots);
        logic [7:0]  codes [KEY_SLOTS_MAX];
        logic [7:0]  fresh;
        bit          any;
        bit          down;
        bit          seen;
        bit          arm;
        logic [3:0]  elen;
        logic [63:0] b;
        int          cps;
        int          dly;
        case (op)
            OP_TICK:
            begin
                if (pending)
                    bind_key(now);
                if (!active)
                    return;
                if (bound == 0)
                begin
                    clear_repeat();
                    return;
                end
                if (earlier(now, due))
                    return;
                if (interval == 0)
                begin
                    clear_repeat();
                    return;
                end
                due = now + TIME_BITS'(interval);
                owe(seq, seq_n, 1'b1, click_on);
            end
            OP_RAW:
            begin
                for (int i = 0; i < KEY_SLOTS_DEFAULT; i++)
                    codes[i] = slots[8*i +: 8];
                // A released bound key ends the repeat.
                if (active && bound != 0)
                begin
                    down = 1'b0;
                    for (int i = 0; i < KEY_SLOTS_DEFAULT; i++)
                        if (codes[i] == bound)
                            down = 1'b1;
                    if (!down)
                        clear_repeat();
                end
                // The first code not held in the previous report is the new press.
                fresh = '0;
                any   = 1'b0;
                for (int i = 0; i < KEY_SLOTS_DEFAULT && fresh == 0; i++)
                begin
                    if (codes[i] != 0)
                    begin
                        any  = 1'b1;
                        seen = 1'b0;
                        for (int j = 0; j < KEY_SLOTS_DEFAULT; j++)
                            if (held[j] == codes[i])
                                seen = 1'b1;
                        if (!seen)
                            fresh = codes[i];
                    end
                end
                for (int i = 0; i < KEY_SLOTS_DEFAULT; i++)
                    if (codes[i] != 0)
                        any = 1'b1;
                if (fresh != 0)
                    pcode = fresh;
                else if (!any)
                    clear_repeat();
                for (int i = 0; i < KEY_SLOTS_DEFAULT; i++)
                    held[i] = codes[i];
                bind_key(now);
            end
            OP_SEQ:
            begin
                if (n == 0)
                begin
                    clear_repeat();
                    owe('0, '0, 1'b0, 1'b0);
                    return;
                end
                elen = (n > 8) ? 4'd8 : n;
                b = bytes;
                if (elen < 8)
                    b = b & ((64'd1 << (8 * elen)) - 64'd1);
                if (active || pending)
                    clear_repeat();
                arm = can_repeat(b, n);
                owe(b, elen, 1'b0, click_on);
                if (arm)
                begin
                    cps      = (rate_cps != 0) ? int'(rate_cps) : int'(DEFAULT_RATE_CPS);
                    dly      = (delay_ms != 0) ? int'(delay_ms) : int'(DEFAULT_DELAY_MS);
                    seq      = b;
                    seq_n    = n;
                    pending  = 1'b1;
                    active   = 1'b0;
                    bound    = '0;
                    interval = INTERVAL_W'(1000000 / cps);
                    due      = now + TIME_BITS'(dly) * TIME_BITS'(1000);
                    bind_key(now);
                end
            end
            OP_REMOVE:
            begin
                clear_repeat();
                foreach (held[i])
                    held[i] = 8'h00;
                pcode = '0;
            end
            OP_CANCEL:
                clear_repeat();
            default: ;
        endcase
    endfunction

    // Compares one emitted sequence with the oldest one owed.
    function void check_result(logic [63:0] bytes, logic [3:0] n, logic rep,
                               logic clk_flag);
        emission_t want;
        results++;
        if (awaited.size() == 0)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch: unexpected result bytes=%h len=%0d repeat=%b click=%b",
                         bytes, n, rep, clk_flag);
            return;
        end
        want = awaited.pop_front();
        if (want.rep)
            repeats++;
        if (want.bytes !== bytes || want.len !== n || want.rep !== rep ||
            want.click !== clk_flag)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch: result %0d expected bytes=%h len=%0d repeat=%b click=%b",
                         results, want.bytes, want.len, want.rep, want.click,
                         "\n          got bytes=%h len=%0d repeat=%b click=%b",
                         bytes, n, rep, clk_flag);
        end
    endfunction

endclass

module testbench;

    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_REQUESTS = 145;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic [2:0]           opcode    = '0;
    logic [TIME_BITS-1:0] now_us    = '0;
    logic [63:0]          seq_bytes = '0;
    logic [3:0]           seq_len   = '0;
    logic [47:0]          key_slots = '0;
    logic                 out_ready = 1'b0;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [3:0]           paddr     = '0;
    logic [31:0]          pwdata    = '0;

    logic                 in_ready;
    logic                 out_valid;
    logic [63:0]          out_bytes;
    logic [3:0]           out_len;
    logic                 is_repeat;
    logic                 click;
    logic [31:0]          prdata;
    logic                 pready;

    repeat_scoreboard     board = new();
    int                   send_idle_pct  = 0;
    int                   recv_idle_pct  = 0;
    int                   quiet_cycles   = 0;
    int                   requests_sent  = 0;
    int                   settings_used  = 0;
    logic [TIME_BITS-1:0] clock_us       = '0;
    logic [47:0]          keys_down      = '0;

    keyboard_typematic_repeat i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .now_us    (now_us),
        .seq_bytes (seq_bytes),
        .seq_len   (seq_len),
        .key_slots (key_slots),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_bytes (out_bytes),
        .out_len   (out_len),
        .is_repeat (is_repeat),
        .click     (click),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result checking, receiver stalls and the idle-cycle count.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            board.check_result(out_bytes, out_len, is_repeat, click);
        if ((out_valid && out_ready) || (in_valid && in_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog.
    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no handshake for %0d cycles, %0d results still owed",
                 WATCHDOG_LIMIT, board.awaited.size());
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // A step near the given span, sometimes zero, exact or well short of it.
    function automatic logic [TIME_BITS-1:0] jitter(input int base);
        case ($urandom_range(7))
            0:       return '0;
            1:       return TIME_BITS'(base - 1);
            2:       return TIME_BITS'(base);
            3:       return TIME_BITS'($urandom_range(base / 2));
            default: return TIME_BITS'(base - base / 4 + $urandom_range(base / 2));
        endcase
    endfunction

    // Presents one request and waits for it to be taken.
    task automatic send_request(input logic [2:0] op, input logic [TIME_BITS-1:0] t,
                                input logic [63:0] b, input logic [3:0] n,
                                input logic [47:0] slots);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        now_us    <= t;
        seq_bytes <= b;
        seq_len   <= n;
        key_slots <= slots;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_request(op, t, b, n, slots);
        if (op <= OP_CANCEL)
            requests_sent++;
    endtask

    task automatic press_tick(input logic [TIME_BITS-1:0] step);
        clock_us += step;
        send_request(OP_TICK, clock_us, rand64(), 4'($urandom), 48'(rand64()));
    endtask

    task automatic type_seq(input logic [63:0] b, input logic [3:0] n);
        send_request(OP_SEQ, clock_us, b, n, 48'(rand64()));
    endtask

    task automatic report_keys(input logic [47:0] slots);
        keys_down = slots;
        send_request(OP_RAW, clock_us, rand64(), 4'($urandom), slots);
    endtask

    task automatic send_plain(input logic [2:0] op);
        send_request(op, clock_us, rand64(), 4'($urandom), 48'(rand64()));
    endtask

    // Stops sending until every owed result is in, then lets the engine settle.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.awaited.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        board.set_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int en, input int dms, input int cps, input int clk_on);
        drain();
        write_register(REG_REPEAT_ENABLE, 32'(en));
        write_register(REG_DELAY_MS, 32'(dms));
        write_register(REG_RATE_CPS, 32'(cps));
        write_register(REG_CLICK_ENABLE, 32'(clk_on));
        settings_used++;
    endtask

    // Picks a sequence: mostly repeatable ones, some near misses and odd lengths.
    task automatic pick_sequence(output logic [63:0] b, output logic [3:0] n);
        b = rand64();
        case ($urandom_range(7))
            0, 1:
            begin
                n = 4'd1;
                b[7:0] = 8'($urandom_range(CH_SPACE, CH_TILDE));
            end
            2:
            begin
                n = 4'd1;
                case ($urandom_range(3))
                    0:       b[7:0] = CH_CR;
                    1:       b[7:0] = CH_LF;
                    2:       b[7:0] = CH_BS;
                    default: b[7:0] = CH_DEL;
                endcase
            end
            3:
            begin
                n = 4'd3;
                b[23:0] = {8'(CH_UP + $urandom_range(3)), CH_BRACK, CH_ESC};
            end
            4:
            begin
                n = 4'd4;
                b[31:0] = {CH_TILDE, CH_THREE, CH_BRACK, CH_ESC};
            end
            5:
            begin
                n = 4'd1;
                b[7:0] = 8'($urandom_range(CH_SPACE - 1));
            end
            6:
                n = 4'($urandom_range(2, 15));
            default:
            begin
                n = 4'($urandom_range(3, 4));
                b[23:0] = {b[23:16], CH_BRACK, CH_ESC};
            end
        endcase
    endtask

    // One key stroke: a sequence, the raw press that binds it, ticks, then an end.
    task automatic type_burst();
        logic [63:0] b;
        logic [3:0]  n;
        logic [7:0]  code;
        logic [47:0] slots;
        int          slot;
        int          ticks;
        int          d_us;
        int          iv_us;
        d_us  = ((board.delay_ms != 0) ? int'(board.delay_ms) : int'(DEFAULT_DELAY_MS)) * 1000;
        iv_us = 1000000 / ((board.rate_cps != 0) ? int'(board.rate_cps)
                                                 : int'(DEFAULT_RATE_CPS));
        slot  = $urandom_range(KEY_SLOTS_DEFAULT - 1);
        if ($urandom_range(19) == 0)
            clock_us = '1 - TIME_BITS'($urandom_range(d_us));
        pick_sequence(b, n);
        clock_us += TIME_BITS'($urandom_range(2000));
        type_seq(b, n);
        if ($urandom_range(99) < 85)
        begin
            code  = 8'($urandom_range(1, 255));
            slots = ($urandom_range(3) == 0) ? 48'h0 : keys_down;
            slots[8*slot +: 8] = code;
            clock_us += TIME_BITS'($urandom_range(3000));
            report_keys(slots);
        end
        ticks = $urandom_range(1, 10);
        press_tick(jitter(d_us));
        for (int k = 1; k < ticks; k++)
        begin
            // Now and then another key joins or replaces one in the report.
            if ($urandom_range(15) == 0)
            begin
                slots = keys_down;
                slots[8*$urandom_range(KEY_SLOTS_DEFAULT - 1) +: 8] = 8'($urandom);
                report_keys(slots);
            end
            press_tick(jitter(iv_us));
        end
        case ($urandom_range(7))
            0, 1:
            begin
                slots = keys_down;
                slots[8*slot +: 8] = 8'h00;
                report_keys(slots);
            end
            2:
                report_keys(48'h0);
            3:
                send_plain(OP_CANCEL);
            4:
            begin
                send_plain(OP_REMOVE);
                keys_down = '0;
            end
            5:
                type_seq(rand64(), 4'd0);
            default: ;
        endcase
    endtask

    task automatic run_phase(input int target);
        int first;
        int pick;
        first = requests_sent;
        while (requests_sent - first < target)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
                send_request(3'($urandom), ($urandom_range(3) == 0) ?
                             TIME_BITS'(rand64()) : clock_us,
                             rand64(), 4'($urandom), 48'(rand64()));
            else if (pick < 14)
                drain();
            else
                type_burst();
        end
    endtask

    initial
    begin
        logic [TIME_BITS-1:0] wrap_at;
        wrap_at = '1 - TIME_BITS'(255);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 18;
        recv_idle_pct = 80;

        // Tick with nothing armed.
        send_request(OP_TICK, 48'd0, '0, '0, '0);
        // Printable character with junk above its length, bound by a new key;
        // repeats at the default delay and rate.
        send_request(OP_SEQ, 48'd100, 64'hFFFF_FFFF_FFFF_FF61, 4'd1, '1);
        send_request(OP_RAW, 48'd1000, '0, '0, 48'h04);
        send_request(OP_TICK, 48'd500099, '1, '1, '1);
        send_request(OP_TICK, 48'd500100, '0, '0, '0);
        send_request(OP_TICK, 48'd600100, '0, '0, '0);
        // Releasing every key stops the repeat.
        send_request(OP_RAW, 48'd650000, '0, '0, '0);
        send_request(OP_TICK, 48'd700100, '0, '0, '0);
        // Arrow key repeating across the time wrap.
        send_request(OP_SEQ, wrap_at, {40'h0, CH_UP, CH_BRACK, CH_ESC}, 4'd3, '0);
        send_request(OP_RAW, wrap_at, '0, '0, 48'h05);
        send_request(OP_TICK, wrap_at + TIME_BITS'(500000), '0, '0, '0);
        // A null key event stops the repeat and is forwarded as an empty sequence.
        send_request(OP_SEQ, wrap_at + TIME_BITS'(600000), '1, 4'd0, '1);
        send_request(OP_TICK, wrap_at + TIME_BITS'(700000), '0, '0, '0);
        // Delete key with several keys held, then a cancel.
        send_request(OP_SEQ, 48'd1000000, {32'h0, CH_TILDE, CH_THREE, CH_BRACK, CH_ESC},
                     4'd4, '0);
        send_request(OP_RAW, 48'd1000000, '0, '0, 48'h07_06_05);
        send_request(OP_CANCEL, 48'd1000000, '0, '0, '0);
        send_request(OP_TICK, 48'd2000000, '0, '0, '0);
        // Long sequence, zero bytes inside the length.
        send_request(OP_SEQ, 48'd2000000, '1, 4'd15, '0);
        send_request(OP_SEQ, 48'd2000000, '0, 4'd3, '1);
        // Carriage return bound by a report full of all-ones codes, then removal.
        send_request(OP_SEQ, 48'd3000000, {56'h0, CH_CR}, 4'd1, '0);
        send_request(OP_RAW, 48'd3000000, '0, '0, '1);
        send_request(OP_REMOVE, 48'd3000000, '0, '0, '0);
        send_request(OP_TICK, 48'd4000000, '0, '0, '0);
        // A key pressed before its sequence binds as soon as the sequence arms.
        send_request(OP_RAW, 48'd5000000, '0, '0, 48'h09);
        send_request(OP_SEQ, 48'd5000000, 64'h7A, 4'd1, '0);
        send_request(OP_TICK, 48'd5500000, '0, '0, '0);
        // Unused opcodes are ignored.
        for (int k = 1; k <= 3; k++)
            send_request(OP_CANCEL + 3'(k), TIME_BITS'(rand64()), rand64(),
                         4'($urandom), 48'(rand64()));

        // Random part: three pacing modes, three register settings each.
        for (int k = 0; k < 9; k++)
        begin
            case (k / 3)
                0:
                begin
                    send_idle_pct = 18;
                    recv_idle_pct = 80;
                end
                1:
                begin
                    send_idle_pct = 80;
                    recv_idle_pct = 18;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (k)
                0:       configure(1, 1, 1000, 1);
                1:       configure(0, 10000, 1, 0);
                2:       configure(1, 10000, 1, 1);
                default: configure(($urandom_range(9) != 0) ? 1 : 0,
                                   ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 60),
                                   ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 1000),
                                   $urandom_range(1));
            endcase
            clock_us = TIME_BITS'(rand64());
            run_phase(PHASE_REQUESTS);
        end

        drain();

        $display("Run covered %0d requests over %0d register settings and three pacing modes.",
                 requests_sent, settings_used);
        $display("Checked %0d results, %0d of them auto-repeats; %0d mismatches.",
                 board.results, board.repeats, board.errors);
        if (board.errors == 0 && board.awaited.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
